// ===== rtl/cped_pkg.sv =====
// ----------------------------------------------------------------------------
// cped_pkg: shared types and constants
// Register indexes, charge state codes and the result struct passed from the
// debounce core to the top level.
// ----------------------------------------------------------------------------
package cped_pkg;

   localparam int unsigned CNT_W     = 8;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [CNT_W-1:0] DEBOUNCE_RESET = CNT_W'(10);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PRESENCE_DEBOUNCE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_DEBOUNCE      = 1'b1;

   // charge_state codes
   localparam logic [1:0] CS_UNKNOWN  = 2'd0;
   localparam logic [1:0] CS_CHARGING = 2'd1;
   localparam logic [1:0] CS_FINISHED = 2'd2;

   typedef struct packed {
      logic       presence_ready;
      logic       charger_present;
      logic [1:0] charge_state;
   } result_type;

endpackage

// ===== rtl/cped_core.sv =====
// ----------------------------------------------------------------------------
// cped_core: presence and charge-end debounce state
// Holds the debounce flags and counters, updates them on each step and
// presents the result for the sample being stepped.
// ----------------------------------------------------------------------------
module cped_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic                      charger_pin,
   input  logic                      charge_end_pin,
   input  logic [cped_pkg::CNT_W-1:0] presence_thr,
   input  logic [cped_pkg::CNT_W-1:0] end_thr,
   output cped_pkg::result_type      result
);

   logic                      primed_ff,         primed_in;
   logic                      present_ff,        present_in;
   logic                      pres_ready_ff,     pres_ready_in;
   logic [cped_pkg::CNT_W-1:0] pres_count_ff,     pres_count_in;
   logic                      ended_ff,          ended_in;
   logic                      end_ready_ff,      end_ready_in;
   logic [cped_pkg::CNT_W-1:0] charging_count_ff, charging_count_in;
   logic [cped_pkg::CNT_W-1:0] ended_count_ff,    ended_count_in;

   logic                      eff_present;
   logic [cped_pkg::CNT_W-1:0] pres_inc;
   logic [cped_pkg::CNT_W-1:0] chg_inc;
   logic [cped_pkg::CNT_W-1:0] end_inc;

   always_comb begin
      // first sample primes presence to the inverse of the pin
      eff_present = primed_ff ? present_ff : ~charger_pin;
      pres_inc    = pres_count_ff + 1'b1;
      chg_inc     = charging_count_ff + 1'b1;
      end_inc     = ended_count_ff + 1'b1;

      primed_in         = 1'b1;
      present_in        = eff_present;
      pres_ready_in     = pres_ready_ff;
      pres_count_in     = '0;
      ended_in          = ended_ff;
      end_ready_in      = end_ready_ff;
      charging_count_in = charging_count_ff;
      ended_count_in    = ended_count_ff;

      // presence debounce
      if (eff_present != charger_pin) begin
         if (pres_inc >= presence_thr) begin
            present_in    = ~eff_present;
            pres_ready_in = 1'b1;
         end else begin
            pres_count_in = pres_inc;
         end
      end

      if (pres_ready_in) begin
         if (present_in) begin
            // charge-end debounce
            if (charge_end_pin == ended_ff) begin
               if (ended_ff) begin
                  charging_count_in = '0;
                  if (end_ready_ff) begin
                     ended_count_in = '0;
                  end else if (end_inc >= end_thr) begin
                     ended_count_in = '0;
                     end_ready_in   = 1'b1;
                  end else begin
                     ended_count_in = end_inc;
                  end
               end else begin
                  ended_count_in = '0;
                  if (end_ready_ff) begin
                     charging_count_in = '0;
                  end else if (chg_inc >= end_thr) begin
                     charging_count_in = '0;
                     end_ready_in      = 1'b1;
                  end else begin
                     charging_count_in = chg_inc;
                  end
               end
            end else if (ended_ff) begin
               // ended, pin says charging
               ended_count_in = '0;
               if (chg_inc >= end_thr) begin
                  charging_count_in = '0;
                  ended_in          = 1'b0;
                  end_ready_in      = 1'b1;
               end else begin
                  charging_count_in = chg_inc;
               end
            end else begin
               // charging, pin says ended
               charging_count_in = '0;
               if (end_inc >= end_thr) begin
                  ended_count_in = '0;
                  ended_in       = 1'b1;
                  end_ready_in   = 1'b1;
               end else begin
                  ended_count_in = end_inc;
               end
            end
         end else begin
            // no charger: clear end status, ended counter kept
            ended_in          = 1'b0;
            end_ready_in      = 1'b0;
            charging_count_in = '0;
         end
      end
   end

   always_comb begin
      result.presence_ready  = pres_ready_in;
      result.charger_present = present_in;
      result.charge_state    = cped_pkg::CS_UNKNOWN;
      if (pres_ready_in && present_in && end_ready_in) begin
         result.charge_state = ended_in ? cped_pkg::CS_FINISHED : cped_pkg::CS_CHARGING;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff         <= 1'b0;
         present_ff        <= 1'b0;
         pres_ready_ff     <= 1'b0;
         pres_count_ff     <= '0;
         ended_ff          <= 1'b0;
         end_ready_ff      <= 1'b0;
         charging_count_ff <= '0;
         ended_count_ff    <= '0;
      end else if (step) begin
         primed_ff         <= primed_in;
         present_ff        <= present_in;
         pres_ready_ff     <= pres_ready_in;
         pres_count_ff     <= pres_count_in;
         ended_ff          <= ended_in;
         end_ready_ff      <= end_ready_in;
         charging_count_ff <= charging_count_in;
         ended_count_ff    <= ended_count_in;
      end
   end

endmodule

// ===== rtl/charger_presence_and_end_debounce_top.sv =====
// ----------------------------------------------------------------------------
// charger_presence_and_end_debounce_top: charger status pin debouncer
// Debounces the charger presence and charge-end pins, one beat per tick.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one beat per sampling tick; tdata carries both pin samples.
//   rsp_*  : one beat per request beat, in order, with the debounced status
//            after that sample (charge_state, presence flag, ready flag).
//   csr_*  : write-only thresholds, index 0 presence, index 1 charge-end.
//            Write only while no beat is in flight.
// Path: a request beat accepted into the input register steps the core and is
//   loaded into the result register, where it waits until it is taken.
// Throughput: one beat per cycle unless stalled. The state update is a single
//   pass of 8-bit increment/compare logic between the input and result registers.
// Stall: if rsp_tready is low the result register holds; the input register
//   still takes one more beat, and req_tready drops only when both are full.
// Reset: synchronous; clears all debounce state and both valids, and sets
//   both thresholds to 10. The first sample after reset primes presence.
// ----------------------------------------------------------------------------
module charger_presence_and_end_debounce_top (
   input  logic                           clock,
   input  logic                           reset,
   // request: [0] charger_pin, [1] charge_end_pin, [7:2] zero
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,
   // response: [1:0] charge_state, [2] charger_present, [3] presence_ready,
   // [7:4] zero
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,
   // configuration
   input  logic                           csr_we,
   input  logic [cped_pkg::CSR_IDX_W-1:0] csr_addr,
   input  logic [cped_pkg::CNT_W-1:0]     csr_wdata
);

   logic                       in_valid_ff, in_valid_in;
   logic [1:0]                 in_pins_ff;
   logic                       out_valid_ff, out_valid_in;
   cped_pkg::result_type       out_data_ff;
   logic [cped_pkg::CNT_W-1:0] pres_thr_ff;
   logic [cped_pkg::CNT_W-1:0] end_thr_ff;

   logic                 advance;
   cped_pkg::result_type core_result;

   // input stage moves into the result register when that is free or drains
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   cped_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .charger_pin    (in_pins_ff[0]),
      .charge_end_pin (in_pins_ff[1]),
      .presence_thr   (pres_thr_ff),
      .end_thr        (end_thr_ff),
      .result         (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_pins_ff <= req_tdata[1:0];
      end
      if (advance) begin
         out_data_ff <= core_result;
      end
   end

   // thresholds
   always_ff @(posedge clock) begin
      if (reset) begin
         pres_thr_ff <= cped_pkg::DEBOUNCE_RESET;
         end_thr_ff  <= cped_pkg::DEBOUNCE_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            cped_pkg::CSR_PRESENCE_DEBOUNCE: pres_thr_ff <= csr_wdata;
            cped_pkg::CSR_END_DEBOUNCE:      end_thr_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_data_ff};

endmodule

// ===== rtl/cped_checker.sv =====
// ----------------------------------------------------------------------------
// cped_checker: port-level checks for the debounce block
// Watches the response channel for illegal status combinations and holds.
// ----------------------------------------------------------------------------
module cped_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // charge_state never uses the spare code
   a_state_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] != 2'd3))
      else $error("illegal charge_state");

   // a known charge status needs a settled, present charger
   a_state_needs_presence: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] != cped_pkg::CS_UNKNOWN)
         |-> (rsp_tdata[2] && rsp_tdata[3]))
      else $error("charge status reported without presence");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind charger_presence_and_end_debounce_top cped_checker u_cped_checker (.*);

// ===== tb/charger_presence_and_end_debounce_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charger_presence_and_end_debounce_top_test: charger debouncer testbench
// Drives pin samples through the request stream and tracks the debounce state
// in a behavioral copy of the block. Every response beat is checked field by
// field against the expected status queue. A short directed sequence covers
// priming, settling, absence clearing and threshold changes. Random phases
// then sweep several threshold settings with stable pin runs plus glitches.
// ----------------------------------------------------------------------------
module charger_presence_and_end_debounce_top_test;

   localparam int CYCLE_LIMIT = 400000;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [7:0]       rsp_tdata;
   logic             csr_we     = 1'b0;
   logic [cped_pkg::CSR_IDX_W-1:0] csr_addr  = '0;
   logic [cped_pkg::CNT_W-1:0]     csr_wdata = '0;

   // expected status for each accepted sample, oldest first
   cped_pkg::result_type status_expected[$];
   int         mismatch_count = 0;
   int         cycle_count    = 0;
   int         stall_left     = 0;
   bit         gaps_on        = 1'b0;

   // behavioral copy of the debounce state and thresholds
   logic [7:0] thr_presence;
   logic [7:0] thr_end;
   logic       is_primed;
   logic       chg_present;
   logic       det_ready;
   logic [7:0] run_presence;
   logic       chg_done;
   logic       done_ready;
   logic [7:0] run_charging;
   logic [7:0] run_done;

   charger_presence_and_end_debounce_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // mostly short idle stretches, now and then a long one
   function automatic int idle_length();
      if ($urandom_range(0, 99) < 80)
         return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   // response back-pressure
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (gaps_on && $urandom_range(0, 99) < 15)
            stall_left <= idle_length();
      end
   end

   // ---------------------------------------------------------------------------
   // Status predictor: presence debounce, then charge-end debounce while a
   // charger is present. Counters are 8 bits and wrap like the hardware.
   // ---------------------------------------------------------------------------
   function automatic void reset_status_model();
      thr_presence = cped_pkg::DEBOUNCE_RESET;
      thr_end      = cped_pkg::DEBOUNCE_RESET;
      is_primed    = 1'b0;
      chg_present  = 1'b0;
      det_ready    = 1'b0;
      run_presence = '0;
      chg_done     = 1'b0;
      done_ready   = 1'b0;
      run_charging = '0;
      run_done     = '0;
   endfunction

   function automatic void track_charge_end(input logic epin);
      if (epin == chg_done) begin
         if (chg_done) begin
            run_charging = '0;
            if (done_ready) begin
               run_done = '0;
            end else begin
               run_done = run_done + 8'd1;
               if (run_done >= thr_end) begin
                  run_done   = '0;
                  done_ready = 1'b1;
               end
            end
         end else begin
            run_done = '0;
            if (done_ready) begin
               run_charging = '0;
            end else begin
               run_charging = run_charging + 8'd1;
               if (run_charging >= thr_end) begin
                  run_charging = '0;
                  done_ready   = 1'b1;
               end
            end
         end
      end else if (chg_done) begin
         // finished, but the pin says charging again
         run_done     = '0;
         run_charging = run_charging + 8'd1;
         if (run_charging >= thr_end) begin
            run_charging = '0;
            chg_done     = 1'b0;
            done_ready   = 1'b1;
         end
      end else begin
         // charging, but the pin says finished
         run_charging = '0;
         run_done     = run_done + 8'd1;
         if (run_done >= thr_end) begin
            run_done   = '0;
            chg_done   = 1'b1;
            done_ready = 1'b1;
         end
      end
   endfunction

   function automatic cped_pkg::result_type predict_status(input logic cpin,
                                                           input logic epin);
      cped_pkg::result_type st;
      st.charge_state = cped_pkg::CS_UNKNOWN;
      // first sample after reset primes presence to the opposite of the pin
      if (!is_primed) begin
         chg_present = ~cpin;
         is_primed   = 1'b1;
      end
      if (chg_present == cpin) begin
         run_presence = '0;
      end else begin
         run_presence = run_presence + 8'd1;
         if (run_presence >= thr_presence) begin
            run_presence = '0;
            chg_present  = ~chg_present;
            det_ready    = 1'b1;
         end
      end
      if (det_ready) begin
         if (chg_present) begin
            track_charge_end(epin);
            if (done_ready)
               st.charge_state = chg_done ? cped_pkg::CS_FINISHED
                                          : cped_pkg::CS_CHARGING;
         end else begin
            // no charger: drop end status, ended run count survives
            chg_done     = 1'b0;
            done_ready   = 1'b0;
            run_charging = '0;
         end
      end
      st.charger_present = chg_present;
      st.presence_ready  = det_ready;
      return st;
   endfunction

   // ---------------------------------------------------------------------------
   // Response checker
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      cped_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (status_expected.size() == 0) begin
            $error("response beat with nothing expected: tdata=%h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = status_expected.pop_front();
            if (rsp_tdata[1:0] !== want.charge_state) begin
               $error("charge_state: expected %0d, got %0d", want.charge_state,
                      rsp_tdata[1:0]);
               mismatch_count++;
            end
            if (rsp_tdata[2] !== want.charger_present) begin
               $error("charger_present: expected %0b, got %0b", want.charger_present,
                      rsp_tdata[2]);
               mismatch_count++;
            end
            if (rsp_tdata[3] !== want.presence_ready) begin
               $error("presence_ready: expected %0b, got %0b", want.presence_ready,
                      rsp_tdata[3]);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Shared stimulus tasks
   // ---------------------------------------------------------------------------
   // one sample beat; valid stays high when the next beat follows at once
   task automatic send_sample(input logic cpin, input logic epin);
      int gap;
      gap = (gaps_on && $urandom_range(0, 99) < 30) ? idle_length() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {6'b0, epin, cpin};
      req_tvalid <= 1'b1;
      status_expected.push_back(predict_status(cpin, epin));
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   // let every beat in flight come out before touching the thresholds
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (status_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [cped_pkg::CSR_IDX_W-1:0] idx,
                                  input logic [7:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == cped_pkg::CSR_PRESENCE_DEBOUNCE)
         thr_presence = value;
      else
         thr_end = value;
   endtask

   // ---------------------------------------------------------------------------
   // Directed: priming, threshold lowered mid-run, settle both ways,
   // absence clearing with the ended run kept, threshold zero
   // ---------------------------------------------------------------------------
   task automatic test_priming_and_settling();
      gaps_on = 1'b0;
      // default thresholds; first beat primes presence high, pin low disagrees
      send_sample(1'b0, 1'b1);
      send_sample(1'b0, 1'b1);
      send_sample(1'b0, 1'b0);
      drain_results();
      // presence run already at 3, so the next disagreeing beat settles
      write_threshold(cped_pkg::CSR_PRESENCE_DEBOUNCE, 8'd1);
      write_threshold(cped_pkg::CSR_END_DEBOUNCE, 8'd2);
      gaps_on = 1'b1;
      send_sample(1'b0, 1'b1);   // absent, detection ready
      send_sample(1'b1, 1'b1);   // present, ended run 1
      send_sample(1'b1, 1'b1);   // finished
      send_sample(1'b1, 1'b0);
      send_sample(1'b1, 1'b0);   // back to charging
      send_sample(1'b1, 1'b1);   // glitch
      send_sample(1'b1, 1'b0);
      send_sample(1'b1, 1'b1);   // ended run 1
      send_sample(1'b0, 1'b1);   // charger gone, ended run kept
      send_sample(1'b1, 1'b1);   // ended run reaches 2 right away
      send_sample(1'b1, 1'b0);
      drain_results();
      // zero thresholds settle on every counted beat
      write_threshold(cped_pkg::CSR_END_DEBOUNCE, 8'd0);
      write_threshold(cped_pkg::CSR_PRESENCE_DEBOUNCE, 8'd0);
      send_sample(1'b1, 1'b0);
      send_sample(1'b1, 1'b1);
      send_sample(1'b0, 1'b1);
      send_sample(1'b1, 1'b0);
      send_sample(1'b1, 1'b1);
      drain_results();
   endtask

   // one threshold setting, pin runs around the threshold with glitches
   task automatic run_phase(input logic [7:0] pres_thr, input logic [7:0] end_thr,
                            input int beats);
      int   sent;
      int   hint;
      int   len;
      int   noise;
      logic c_lvl;
      logic e_lvl;
      logic cp;
      logic ep;
      sent = 0;
      write_threshold(cped_pkg::CSR_PRESENCE_DEBOUNCE, pres_thr);
      write_threshold(cped_pkg::CSR_END_DEBOUNCE, end_thr);
      hint  = (pres_thr > end_thr) ? pres_thr : end_thr;
      if (hint == 0)
         hint = 1;
      e_lvl = 1'($urandom_range(0, 1));
      while (sent < beats) begin
         c_lvl   = 1'($urandom_range(0, 1));
         len     = $urandom_range(hint / 2 + 1, 2 * hint + 3);
         noise   = ($urandom_range(0, 9) < 3) ? 10 : 0;
         gaps_on = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < len && sent < beats; i++) begin
            // charge-end level moves on its own, slower than presence
            if ($urandom_range(0, 2 * end_thr + 2) == 0)
               e_lvl = ~e_lvl;
            cp = c_lvl;
            ep = e_lvl;
            if ($urandom_range(0, 99) < noise)
               cp = ~cp;
            if ($urandom_range(0, 99) < noise)
               ep = ~ep;
            send_sample(cp, ep);
            sent++;
         end
      end
      drain_results();
   endtask

   task automatic test_random_phases();
      run_phase(8'd10, 8'd10, 130);
      run_phase(8'd1, 8'd1, 130);
      run_phase(8'd255, 8'd255, 500);
      run_phase(8'd0, 8'd3, 100);
      run_phase(8'($urandom_range(1, 20)), 8'($urandom_range(1, 20)), 130);
      run_phase(8'($urandom_range(1, 20)), 8'($urandom_range(1, 20)), 130);
      run_phase(8'd2, 8'd1, 100);
   endtask

   initial begin
      reset_status_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_priming_and_settling();
      test_random_phases();
      gaps_on = 1'b0;
      drain_results();
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== charger_presence_and_end_debounce_top.f =====
rtl/cped_pkg.sv
rtl/cped_core.sv
rtl/charger_presence_and_end_debounce_top.sv
rtl/cped_checker.sv
tb/charger_presence_and_end_debounce_top_test.sv
